// ===== rtl/ppc_pkg.sv =====
`timescale 1ns / 1ps

package ppc_pkg;

    // Default sizing of the collection
    localparam int CAPACITY_DEF      = 64;
    localparam int VALUE_BITS_DEF    = 32;
    localparam int PRIORITY_BITS_DEF = 16;
    localparam int LOWEST_PRIORITY   = 0;

    // Operation codes
    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_PROMOTE = 3'd1;
    localparam logic [2:0] OP_PEEK    = 3'd2;
    localparam logic [2:0] OP_POP     = 3'd3;
    localparam logic [2:0] OP_LOOKUP  = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] item_id;
        logic [31:0] item_value;
    } ppc_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] id_out;
        logic [31:0] value_out;
        logic [15:0] priority_out;
        logic        is_live;
    } ppc_out_t;

    // What the slot scan has found so far
    typedef struct packed {
        logic free;
        logic hit;
        logic best;
    } ppc_found_t;

endpackage

// ===== rtl/promotable_priority_collection.sv =====
`timescale 1ns / 1ps

// Bounded priority collection with promote. Each command beat (add, promote,
// peek max, pop max, lookup id) yields exactly one result beat. All slots live
// in one single-port-write slot RAM with a registered read; every
// command sweeps the whole RAM one slot per cycle: SCAN reads every slot,
// DRAIN lets the last read return, and FINISH, once the result register
// is free, writes back and loads it. The sweep finds the lowest free slot,
// the lowest live slot whose id matches and the max entry (highest
// priority, then largest id, then lowest slot) in one pass. The next
// command is taken as soon as the previous one has loaded its result,
// even while that result still waits on m_ready. After reset the block
// clears the slot RAM, which holds s_ready low until every slot is written.
// Ids come from a 32-bit counter that wraps; add at priority zero, promote
// saturates at the top priority. Full table, unknown id and empty collection
// report an error status with all other result fields zero.
module promotable_priority_collection #(
    parameter int CAPACITY      = ppc_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS    = ppc_pkg::VALUE_BITS_DEF,
    parameter int PRIORITY_BITS = ppc_pkg::PRIORITY_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ppc_pkg::ppc_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output ppc_pkg::ppc_out_t m_data
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int WORD_W = 1 + 32 + VALUE_BITS + PRIORITY_BITS;
    localparam logic [IDX_W-1:0]         LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [PRIORITY_BITS-1:0] PRIO_TOP = '1;
    localparam logic [PRIORITY_BITS-1:0] PRIO_LOW =
        PRIORITY_BITS'(ppc_pkg::LOWEST_PRIORITY);

    typedef enum logic [2:0] {
        CLEARING,
        IDLE,
        SCAN,
        DRAIN,
        FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              cmp_en_reg, cmp_en_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    ppc_pkg::ppc_in_t  req_reg, req_next;
    logic [31:0]       next_id_reg, next_id_next;
    logic              m_valid_reg, m_valid_next;
    ppc_pkg::ppc_out_t m_data_reg, m_data_next;

    // Slot RAM port signals; word layout {valid, id, value, priority}
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [WORD_W-1:0] ram_rdata;

    logic                     ent_valid;
    logic [31:0]              ent_id;
    logic [VALUE_BITS-1:0]    ent_value;
    logic [PRIORITY_BITS-1:0] ent_prio;

    logic                     scan_start;
    ppc_pkg::ppc_found_t      found;
    logic [IDX_W-1:0]         free_idx;
    logic [IDX_W-1:0]         hit_idx;
    logic [VALUE_BITS-1:0]    hit_value;
    logic [PRIORITY_BITS-1:0] hit_prio;
    logic [IDX_W-1:0]         best_idx;
    logic [31:0]              best_id;
    logic [VALUE_BITS-1:0]    best_value;
    logic [PRIORITY_BITS-1:0] best_prio;

    // Write-back and result of the command under way
    ppc_pkg::ppc_out_t        result;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_idx;
    logic [WORD_W-1:0]        wr_word;
    logic                     id_bump;
    logic [VALUE_BITS-1:0]    add_value;
    logic [PRIORITY_BITS-1:0] new_prio;

    ppc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign ent_valid = ram_rdata[WORD_W-1];
    assign ent_id    = ram_rdata[WORD_W-2 -: 32];
    assign ent_value = ram_rdata[PRIORITY_BITS +: VALUE_BITS];
    assign ent_prio  = ram_rdata[PRIORITY_BITS-1:0];

    ppc_scan #(
        .IDX_W         (IDX_W),
        .VALUE_BITS    (VALUE_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (scan_start),
        .cmp_en     (cmp_en_reg),
        .cmp_idx    (cmp_idx_reg),
        .ent_valid  (ent_valid),
        .ent_id     (ent_id),
        .ent_value  (ent_value),
        .ent_prio   (ent_prio),
        .key_id     (req_reg.item_id),
        .found      (found),
        .free_idx   (free_idx),
        .hit_idx    (hit_idx),
        .hit_value  (hit_value),
        .hit_prio   (hit_prio),
        .best_idx   (best_idx),
        .best_id    (best_id),
        .best_value (best_value),
        .best_prio  (best_prio)
    );

    assign add_value = VALUE_BITS'(req_reg.item_value);
    assign new_prio  = (hit_prio == PRIO_TOP) ? hit_prio : hit_prio + PRIORITY_BITS'(1);

    // Decide the result and the single slot write once the sweep is complete
    always_comb begin
        result  = '0;
        wr_en   = 1'b0;
        wr_idx  = free_idx;
        wr_word = '0;
        id_bump = 1'b0;
        case (req_reg.operation) inside
            ppc_pkg::OP_ADD: begin
                if (found.free) begin
                    result.status       = ppc_pkg::ST_OK;
                    result.id_out       = next_id_reg;
                    result.value_out    = 32'(add_value);
                    result.priority_out = 16'(PRIO_LOW);
                    result.is_live      = 1'b1;
                    wr_en   = 1'b1;
                    wr_idx  = free_idx;
                    wr_word = {1'b1, next_id_reg, add_value, PRIO_LOW};
                    id_bump = 1'b1;
                end else begin
                    result.status = ppc_pkg::ST_FULL;
                end
            end
            ppc_pkg::OP_PROMOTE: begin
                if (found.hit) begin
                    result.status       = ppc_pkg::ST_OK;
                    result.id_out       = req_reg.item_id;
                    result.value_out    = 32'(hit_value);
                    result.priority_out = 16'(new_prio);
                    result.is_live      = 1'b1;
                    wr_en   = 1'b1;
                    wr_idx  = hit_idx;
                    wr_word = {1'b1, req_reg.item_id, hit_value, new_prio};
                end else begin
                    result.status = ppc_pkg::ST_UNKNOWN;
                end
            end
            ppc_pkg::OP_PEEK, ppc_pkg::OP_POP: begin
                if (found.best) begin
                    result.status       = ppc_pkg::ST_OK;
                    result.id_out       = best_id;
                    result.value_out    = 32'(best_value);
                    result.priority_out = 16'(best_prio);
                    result.is_live      = (req_reg.operation != ppc_pkg::OP_POP);
                    // Pop frees the slot: rewrite it with the valid bit dropped
                    wr_en   = (req_reg.operation == ppc_pkg::OP_POP);
                    wr_idx  = best_idx;
                    wr_word = {1'b0, best_id, best_value, best_prio};
                end else begin
                    result.status = ppc_pkg::ST_EMPTY;
                end
            end
            ppc_pkg::OP_LOOKUP: begin
                if (found.hit) begin
                    result.status       = ppc_pkg::ST_OK;
                    result.id_out       = req_reg.item_id;
                    result.value_out    = 32'(hit_value);
                    result.priority_out = 16'(hit_prio);
                    result.is_live      = 1'b1;
                end else begin
                    result.status = ppc_pkg::ST_UNKNOWN;
                end
            end
            default: begin
                // Unused operation codes answer ok with all fields zero
                result.status = ppc_pkg::ST_OK;
            end
        endcase
    end

    // Sequencer: clear pass, accept, sweep, drain the last read, write back.
    // The write-back in FINISH lands before the next sweep issues its first
    // read, so a command always sees the previous command's update.
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmp_en_next  = 1'b0;
        cmp_idx_next = idx_reg;
        req_next     = req_reg;
        next_id_next = next_id_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        scan_start   = 1'b0;
        unique case (state_reg)
            CLEARING: begin
                ram_we   = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = IDLE;
                end
            end
            IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    scan_start = 1'b1;
                    idx_next   = '0;
                    state_next = SCAN;
                end
            end
            SCAN: begin
                ram_re      = 1'b1;
                cmp_en_next = 1'b1;
                idx_next    = idx_reg + IDX_W'(1);
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = DRAIN;
                end
            end
            DRAIN: begin
                state_next = FINISH;
            end
            FINISH: begin
                // Hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = result;
                    ram_we       = wr_en;
                    ram_waddr    = wr_idx;
                    ram_wdata    = wr_word;
                    if (id_bump) begin
                        next_id_next = next_id_reg + 32'd1;
                    end
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CLEARING;
            idx_reg     <= '0;
            cmp_en_reg  <= 1'b0;
            next_id_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cmp_en_reg  <= cmp_en_next;
            next_id_reg <= next_id_next;
            m_valid_reg <= m_valid_next;
        end
        cmp_idx_reg <= cmp_idx_next;
        req_reg     <= req_next;
        m_data_reg  <= m_data_next;
    end

    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/ppc_ram.sv =====
`timescale 1ns / 1ps

module ppc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ppc_scan.sv =====
`timescale 1ns / 1ps

module ppc_scan #(
    parameter int IDX_W         = 6,
    parameter int VALUE_BITS    = 32,
    parameter int PRIORITY_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic                     cmp_en,
    input  logic [IDX_W-1:0]         cmp_idx,
    input  logic                     ent_valid,
    input  logic [31:0]              ent_id,
    input  logic [VALUE_BITS-1:0]    ent_value,
    input  logic [PRIORITY_BITS-1:0] ent_prio,
    input  logic [31:0]              key_id,
    output ppc_pkg::ppc_found_t      found,
    output logic [IDX_W-1:0]         free_idx,
    output logic [IDX_W-1:0]         hit_idx,
    output logic [VALUE_BITS-1:0]    hit_value,
    output logic [PRIORITY_BITS-1:0] hit_prio,
    output logic [IDX_W-1:0]         best_idx,
    output logic [31:0]              best_id,
    output logic [VALUE_BITS-1:0]    best_value,
    output logic [PRIORITY_BITS-1:0] best_prio
);

    ppc_pkg::ppc_found_t      found_reg;
    logic [IDX_W-1:0]         free_idx_reg;
    logic [IDX_W-1:0]         hit_idx_reg;
    logic [VALUE_BITS-1:0]    hit_value_reg;
    logic [PRIORITY_BITS-1:0] hit_prio_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic [31:0]              best_id_reg;
    logic [VALUE_BITS-1:0]    best_value_reg;
    logic [PRIORITY_BITS-1:0] best_prio_reg;
    logic                     take_free;
    logic                     take_hit;
    logic                     take_best;

    // Lowest free slot, lowest live slot with the key, best live slot
    assign take_free = cmp_en && !ent_valid && !found_reg.free;
    assign take_hit  = cmp_en && ent_valid && (ent_id == key_id) && !found_reg.hit;
    assign take_best = cmp_en && ent_valid &&
                       (!found_reg.best || (ent_prio > best_prio_reg) ||
                        ((ent_prio == best_prio_reg) && (ent_id > best_id_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn || start) begin
            found_reg <= '0;
        end else begin
            if (take_free) begin
                found_reg.free <= 1'b1;
            end
            if (take_hit) begin
                found_reg.hit <= 1'b1;
            end
            if (take_best) begin
                found_reg.best <= 1'b1;
            end
        end
        if (take_free) begin
            free_idx_reg <= cmp_idx;
        end
        if (take_hit) begin
            hit_idx_reg   <= cmp_idx;
            hit_value_reg <= ent_value;
            hit_prio_reg  <= ent_prio;
        end
        if (take_best) begin
            best_idx_reg   <= cmp_idx;
            best_id_reg    <= ent_id;
            best_value_reg <= ent_value;
            best_prio_reg  <= ent_prio;
        end
    end

    assign found      = found_reg;
    assign free_idx   = free_idx_reg;
    assign hit_idx    = hit_idx_reg;
    assign hit_value  = hit_value_reg;
    assign hit_prio   = hit_prio_reg;
    assign best_idx   = best_idx_reg;
    assign best_id    = best_id_reg;
    assign best_value = best_value_reg;
    assign best_prio  = best_prio_reg;

endmodule

// ===== rtl/ppc_checker.sv =====
`timescale 1ns / 1ps

module ppc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input ppc_pkg::ppc_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input ppc_pkg::ppc_out_t m_data
);

    // A stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // One command at a time: accepting a beat closes the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second command accepted during a sweep");

    // Error statuses carry all-zero fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ppc_pkg::ST_FULL ||
                    m_data.status == ppc_pkg::ST_UNKNOWN ||
                    m_data.status == ppc_pkg::ST_EMPTY)
        |-> m_data.id_out == '0 && m_data.value_out == '0 &&
            m_data.priority_out == '0 && !m_data.is_live)
        else $error("error result with nonzero fields");

    // Reset starts the clear pass: nothing accepted, nothing offered
    assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block active right after reset");

endmodule

bind promotable_priority_collection ppc_checker u_ppc_checker (.*);
